>>> rtl/core/rgbc_pkg.sv
// shared types, constants and register codes of the rgb 3x3 convolution block
package rgbc_pkg;

    localparam int KERNEL_SIZE  = 3;
    localparam int CHANNELS     = 3;
    localparam int CH_W         = 8;
    localparam int PIX_W        = CHANNELS * CH_W;
    localparam int COEF_W       = 12;
    localparam int FRAC_BITS    = 4;
    localparam int KROW_W       = KERNEL_SIZE * COEF_W;
    localparam int PROD_W       = CH_W + 1 + COEF_W;
    localparam int ACC_W        = 25;
    localparam int COORD_W      = 11;
    localparam int FRAME_DIM_W  = 12;
    localparam int MIN_FRAME_DIM = 3;
    localparam int CH_MAX       = 255;
    localparam int BIAS_VALUE   = 127;
    localparam int BIAS_Q4      = BIAS_VALUE * (1 << FRAC_BITS);

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KROW_W;

    localparam logic [CFG_IDX_W-1:0] REG_KERN_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_BIAS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 3'd5;

    localparam logic [KROW_W-1:0]      KERN_TOP_RST = '0;
    localparam logic [KROW_W-1:0]      KERN_MID_RST = KROW_W'(16);
    localparam logic [KROW_W-1:0]      KERN_BOT_RST = '0;
    localparam logic [FRAME_DIM_W-1:0] FRAME_W_RST  = FRAME_DIM_W'(640);
    localparam logic [FRAME_DIM_W-1:0] FRAME_H_RST  = FRAME_DIM_W'(480);

    localparam int OUT_TDATA_W = 48;

    typedef logic [PIX_W-1:0]          pix_t;
    typedef logic [COEF_W-1:0]         coef_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // enables of the tap cells, one per pipeline step
    typedef struct packed {
        logic en_mul;
        logic en_acc;
    } cell_ctl_t;

    typedef struct packed {
        logic               last;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    red;
    } out_word_t;

endpackage

>>> rtl/core/rgbc_line_ram.sv
// single line store: one write port, one read port with registered read data
module rgbc_line_ram #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 24
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/rgbc_tap_cell.sv
// one window column of the transposed convolution chain: products, then running sum
module rgbc_tap_cell import rgbc_pkg::*; (
    input  logic                           aclk,
    input  cell_ctl_t                      ctl,
    input  pix_t  [KERNEL_SIZE-1:0]        col_pix,
    input  coef_t [KERNEL_SIZE-1:0]        weight,
    input  acc_t  [CHANNELS-1:0]           partial_in,
    output acc_t  [CHANNELS-1:0]           acc_out
);

    prod_t prod_reg [KERNEL_SIZE][CHANNELS];
    acc_t  acc_reg  [CHANNELS];
    acc_t  acc_next [CHANNELS];
    acc_t  sum_tmp  [CHANNELS];

    always_ff @(posedge aclk) begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (ctl.en_mul) begin
                    prod_reg[r][ch] <= $signed({1'b0, col_pix[r][ch*CH_W +: CH_W]})
                                       * $signed(weight[r]);
                end
            end
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (ctl.en_acc) begin
                acc_reg[ch] <= acc_next[ch];
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            sum_tmp[ch] = $signed(partial_in[ch]);
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                sum_tmp[ch] = sum_tmp[ch] + ACC_W'(prod_reg[r][ch]);
            end
            acc_next[ch] = sum_tmp[ch];
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            acc_out[ch] = acc_reg[ch];
        end
    end

endmodule

>>> rtl/core/rgbc_out_buf.sv
// two-entry result buffer in front of the master port
module rgbc_out_buf import rgbc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_word_t push_data,
    output logic      full,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    out_word_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/rgb_3x3_convolution_clamp.sv
// top level: raster rgb stream through two line stores and a chain of three tap cells
// order: a result passes stages one to three and the two-entry result buffer before the master
//   port offers it; a word that releases two results offers its interior result first
// throughput: one word per cycle while the result buffer has room; a word that releases two
//   results (interior pixel and ring pixel) holds the slave port until both are pushed one by one
// reset: synchronous active-low aresetn clears counters, pipeline valids, the result buffer
module rgb_3x3_convolution_clamp import rgbc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIX_W-1:0]       s_tdata,     // in_red, in_green, in_blue
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,     // out_red, out_green, out_blue, out_column, out_row
    output logic                   m_tlast,     // last_of_run
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    // register defaults are loaded at reset; the line stores are not cleared

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int DIM_W    = (DIM_BITS > FRAME_DIM_W) ? DIM_BITS : FRAME_DIM_W;

    // configuration registers, kernel rows indexed top to bottom
    logic [KROW_W-1:0]      kern_row_reg [KERNEL_SIZE];
    logic                   add_bias_reg;
    logic [FRAME_DIM_W-1:0] frame_w_reg;
    logic [FRAME_DIM_W-1:0] frame_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kern_row_reg[0] <= KERN_TOP_RST;
            kern_row_reg[1] <= KERN_MID_RST;
            kern_row_reg[2] <= KERN_BOT_RST;
            add_bias_reg    <= 1'b0;
            frame_w_reg     <= FRAME_W_RST;
            frame_h_reg     <= FRAME_H_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KERN_TOP: kern_row_reg[0] <= cfg_wr_data;
                REG_KERN_MID: kern_row_reg[1] <= cfg_wr_data;
                REG_KERN_BOT: kern_row_reg[2] <= cfg_wr_data;
                REG_ADD_BIAS: add_bias_reg    <= cfg_wr_data[0];
                REG_FRAME_W:  frame_w_reg     <= cfg_wr_data[FRAME_DIM_W-1:0];
                REG_FRAME_H:  frame_h_reg     <= cfg_wr_data[FRAME_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [DIM_W-1:0] w_eff, h_eff, fw_ext, fh_ext;

    always_comb begin
        fw_ext = DIM_W'(frame_w_reg);
        fh_ext = DIM_W'(frame_h_reg);
        if (fw_ext < DIM_W'(MIN_FRAME_DIM)) begin
            w_eff = DIM_W'(MIN_FRAME_DIM);
        end else if (fw_ext > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        if (fh_ext < DIM_W'(MIN_FRAME_DIM)) begin
            h_eff = DIM_W'(MIN_FRAME_DIM);
        end else if (fh_ext > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = fh_ext;
        end
    end

    // pipeline control
    logic adv, accept;
    logic v1_reg, v2_reg, v3_reg;

    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // position of the next word
    logic [CW-1:0]    col_cnt_reg, col_cnt_next;
    logic [RW-1:0]    row_cnt_reg, row_cnt_next;
    logic [DIM_W-1:0] c_ext, r_ext;
    logic             interior0, ring0;

    always_comb begin
        c_ext = DIM_W'(col_cnt_reg);
        r_ext = DIM_W'(row_cnt_reg);
        interior0 = (c_ext >= DIM_W'(2)) && (c_ext <= w_eff - DIM_W'(1))
                 && (r_ext >= DIM_W'(2)) && (r_ext <= h_eff - DIM_W'(1));
        ring0 = (c_ext == '0) || (c_ext >= w_eff - DIM_W'(1))
             || (r_ext == '0) || (r_ext >= h_eff - DIM_W'(1));
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept) begin
            if (c_ext + DIM_W'(1) >= w_eff) begin
                col_cnt_next = '0;
                if (r_ext + DIM_W'(1) >= h_eff) begin
                    row_cnt_next = '0;
                end else begin
                    row_cnt_next = row_cnt_reg + RW'(1);
                end
            end else begin
                col_cnt_next = col_cnt_reg + CW'(1);
            end
        end
    end

    // stage payloads
    pix_t          pix1_reg, pix2_reg, pix3_reg;
    logic [CW-1:0] c1_reg, c2_reg, c3_reg;
    logic [RW-1:0] r1_reg, r2_reg, r3_reg;
    logic          int1_reg, int2_reg, int3_reg;
    logic          ring1_reg, ring2_reg, ring3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (adv) begin
                v1_reg <= accept;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
        if (adv) begin
            pix1_reg  <= s_tdata;
            c1_reg    <= col_cnt_reg;
            r1_reg    <= row_cnt_reg;
            int1_reg  <= interior0;
            ring1_reg <= ring0;
            pix2_reg  <= pix1_reg;
            c2_reg    <= c1_reg;
            r2_reg    <= r1_reg;
            int2_reg  <= int1_reg;
            ring2_reg <= ring1_reg;
            pix3_reg  <= pix2_reg;
            c3_reg    <= c2_reg;
            r3_reg    <= r2_reg;
            int3_reg  <= int2_reg;
            ring3_reg <= ring2_reg;
        end
    end

    // line stores: read at accept, written back when the word leaves stage one
    pix_t above_rd, two_above_rd;
    logic ls_wr;

    assign ls_wr = adv && v1_reg;

    rgbc_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W)) u_above (
        .aclk    (aclk),
        .wr_en   (ls_wr),
        .wr_addr (c1_reg),
        .wr_data (pix1_reg),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (above_rd)
    );

    rgbc_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W)) u_two_above (
        .aclk    (aclk),
        .wr_en   (ls_wr),
        .wr_addr (c1_reg),
        .wr_data (above_rd),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (two_above_rd)
    );

    // tap cell chain, cell j holds window column j (0 is two to the left)
    cell_ctl_t                     cell_ctl;
    pix_t  [KERNEL_SIZE-1:0]       col_pix;
    coef_t [KERNEL_SIZE-1:0]       cell_weight [KERNEL_SIZE];
    acc_t  [CHANNELS-1:0]          cell_acc    [KERNEL_SIZE];
    acc_t  [CHANNELS-1:0]          cell_part   [KERNEL_SIZE];

    assign cell_ctl.en_mul = adv && v1_reg;
    assign cell_ctl.en_acc = adv && v2_reg;
    assign col_pix[0] = two_above_rd;
    assign col_pix[1] = above_rd;
    assign col_pix[2] = pix1_reg;

    genvar gj, gi;
    generate
        for (gj = 0; gj < KERNEL_SIZE; gj++) begin : g_cell
            // kernel rotated half a turn: window (i, j) takes coefficient (2-i, 2-j)
            for (gi = 0; gi < KERNEL_SIZE; gi++) begin : g_w
                assign cell_weight[gj][gi] =
                    kern_row_reg[KERNEL_SIZE-1-gi][(KERNEL_SIZE-1-gj)*COEF_W +: COEF_W];
            end
            if (gj == 0) begin : g_first
                assign cell_part[gj] = '0;
            end else begin : g_next
                assign cell_part[gj] = cell_acc[gj-1];
            end
            rgbc_tap_cell u_cell (
                .aclk       (aclk),
                .ctl        (cell_ctl),
                .col_pix    (col_pix),
                .weight     (cell_weight[gj]),
                .partial_in (cell_part[gj]),
                .acc_out    (cell_acc[gj])
            );
        end
    endgenerate

    // bias and clamp of the finished sums
    logic [CH_W-1:0] conv_ch [CHANNELS];
    acc_t            biased  [CHANNELS];

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            biased[ch] = $signed(cell_acc[KERNEL_SIZE-1][ch])
                       + (add_bias_reg ? ACC_W'(BIAS_Q4) : ACC_W'(0));
            if (biased[ch][ACC_W-1]) begin
                conv_ch[ch] = '0;
            end else if (biased[ch][ACC_W-2:FRAC_BITS+CH_W] != '0) begin
                conv_ch[ch] = CH_W'(CH_MAX);
            end else begin
                conv_ch[ch] = biased[ch][FRAC_BITS +: CH_W];
            end
        end
    end

    // result push from stage three
    logic      second_reg, second_next;
    logic      push_req, push_ok, both, retire;
    out_word_t push_word;
    logic      buf_full;

    assign both     = int3_reg && ring3_reg;
    assign push_req = v3_reg && (int3_reg || ring3_reg);
    assign push_ok  = !buf_full;
    assign retire   = push_ok && (!both || second_reg);
    assign adv      = !v3_reg || !(int3_reg || ring3_reg) || retire;

    always_comb begin
        second_next = second_reg;
        if (push_req && push_ok && both) begin
            second_next = !second_reg;
        end
        if (int3_reg && !second_reg) begin
            push_word.red    = conv_ch[0];
            push_word.green  = conv_ch[1];
            push_word.blue   = conv_ch[2];
            push_word.column = COORD_W'(c3_reg - CW'(1));
            push_word.row    = COORD_W'(r3_reg - RW'(1));
            push_word.last   = !ring3_reg;
        end else begin
            push_word.red    = pix3_reg[0 +: CH_W];
            push_word.green  = pix3_reg[CH_W +: CH_W];
            push_word.blue   = pix3_reg[2*CH_W +: CH_W];
            push_word.column = COORD_W'(c3_reg);
            push_word.row    = COORD_W'(r3_reg);
            push_word.last   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else begin
            second_reg <= second_next;
        end
    end

    out_word_t out_word;

    rgbc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_req && push_ok),
        .push_data (push_word),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = OUT_TDATA_W'({out_word.row, out_word.column, out_word.blue,
                                   out_word.green, out_word.red});
    assign m_tlast = out_word.last;

endmodule

>>> dv/rgb_3x3_convolution_clamp_test.sv
// testbench of the rgb 3x3 convolution block: predicted pixel stream checked word by word
`timescale 1ns / 1ps

module rgb_3x3_convolution_clamp_test import rgbc_pkg::*; ();

    localparam int FRAME_MIN       = 3;
    localparam int BIAS_SIXTEENTHS = 127 * 16;
    localparam int CHANNEL_TOP     = 255;
    localparam logic [COEF_W-1:0] COEF_POS_MAX = 12'h7FF;
    localparam logic [COEF_W-1:0] COEF_NEG_MAX = 12'h800;
    localparam logic [COEF_W-1:0] COEF_UNITY   = 12'd16;

    // keeps its own copy of the line stores and window and the expected result pixels
    class filtered_pixel_tracker;
        logic [KROW_W-1:0]      kernel_row [3];
        bit                     bias_on;
        logic [FRAME_DIM_W-1:0] width_reg;
        logic [FRAME_DIM_W-1:0] height_reg;
        pix_t                   row_above [DEF_MAX_WIDTH];
        pix_t                   row_two_above [DEF_MAX_WIDTH];
        pix_t                   col_prev [3];
        pix_t                   col_prev2 [3];
        int unsigned            col_pos;
        int unsigned            row_pos;
        out_word_t              expected_pixels [$];
        int unsigned            mismatches;

        function new();
            kernel_row[0] = KERN_TOP_RST;
            kernel_row[1] = KERN_MID_RST;
            kernel_row[2] = KERN_BOT_RST;
            bias_on = 1'b0;
            width_reg = FRAME_W_RST;
            height_reg = FRAME_H_RST;
            foreach (row_above[i]) begin
                row_above[i] = '0;
                row_two_above[i] = '0;
            end
            col_prev = '{'0, '0, '0};
            col_prev2 = '{'0, '0, '0};
            col_pos = 0;
            row_pos = 0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_KERN_TOP: kernel_row[0] = val;
                REG_KERN_MID: kernel_row[1] = val;
                REG_KERN_BOT: kernel_row[2] = val;
                REG_ADD_BIAS: bias_on = val[0];
                REG_FRAME_W:  width_reg = val[FRAME_DIM_W-1:0];
                REG_FRAME_H:  height_reg = val[FRAME_DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamped(logic [FRAME_DIM_W-1:0] v, int unsigned limit);
            if (v < FRAME_MIN) return FRAME_MIN;
            if (v > limit) return limit;
            return v;
        endfunction

        function int unsigned frame_pixels();
            return clamped(width_reg, DEF_MAX_WIDTH) * clamped(height_reg, DEF_MAX_HEIGHT);
        endfunction

        // win[i][j]: row i (0 is two rows up), column j (0 is two columns left)
        function logic [CH_W-1:0] filter_channel(pix_t win [3][3], int ch);
            int sum;
            int i;
            int j;
            logic signed [COEF_W-1:0] cf;
            logic [CH_W-1:0] px;
            sum = 0;
            for (i = 0; i < 3; i++) begin
                for (j = 0; j < 3; j++) begin
                    // kernel applied turned by half a turn
                    cf = kernel_row[2 - i][COEF_W * (2 - j) +: COEF_W];
                    px = win[i][j][CH_W * ch +: CH_W];
                    sum += int'(px) * int'(cf);
                end
            end
            if (bias_on) sum += BIAS_SIXTEENTHS;
            if (sum < 0) return '0;
            if (sum / 16 > CHANNEL_TOP) return CH_W'(CHANNEL_TOP);
            return CH_W'(sum / 16);
        endfunction

        function void take_pixel(pix_t cur);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned idx;
            pix_t top;
            pix_t mid;
            pix_t win [3][3];
            out_word_t res;
            bit ring;
            bit interior;
            int i;
            w = clamped(width_reg, DEF_MAX_WIDTH);
            h = clamped(height_reg, DEF_MAX_HEIGHT);
            c = col_pos;
            r = row_pos;
            idx = (c < DEF_MAX_WIDTH) ? c : DEF_MAX_WIDTH - 1;
            top = row_two_above[idx];
            mid = row_above[idx];
            interior = c >= 2 && c <= w - 1 && r >= 2 && r <= h - 1;
            ring = c == 0 || c >= w - 1 || r == 0 || r >= h - 1;
            if (interior) begin
                for (i = 0; i < 3; i++) begin
                    win[i][0] = col_prev2[i];
                    win[i][1] = col_prev[i];
                end
                win[0][2] = top;
                win[1][2] = mid;
                win[2][2] = cur;
                res.red = filter_channel(win, 0);
                res.green = filter_channel(win, 1);
                res.blue = filter_channel(win, 2);
                res.column = COORD_W'(c - 1);
                res.row = COORD_W'(r - 1);
                res.last = !ring;
                expected_pixels.insert(expected_pixels.size(), res);
            end
            if (ring) begin
                res.red = cur[0 +: CH_W];
                res.green = cur[CH_W +: CH_W];
                res.blue = cur[2 * CH_W +: CH_W];
                res.column = COORD_W'(c);
                res.row = COORD_W'(r);
                res.last = 1'b1;
                expected_pixels.insert(expected_pixels.size(), res);
            end
            col_prev2 = col_prev;
            col_prev = '{top, mid, cur};
            row_two_above[idx] = mid;
            row_above[idx] = cur;
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_pixel(logic [OUT_TDATA_W-1:0] data, logic last);
            out_word_t got;
            out_word_t want;
            got = {last, data[2 * COORD_W + PIX_W - 1:0]};
            if (expected_pixels.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, got row %0d col %0d",
                         $time, got.row, got.column);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("column", want.column, got.column);
            check_field("row", want.row, got.row);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    int src_idle_pct      = 0;
    int sink_stall_pct    = 0;
    int sink_hold_cycles  = 0;

    filtered_pixel_tracker sb = new();

    rgb_3x3_convolution_clamp i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, plus a long hold-off counted down here
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_tready <= 1'b0;
                sink_hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.compare_pixel(m_tdata, m_tlast);
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_pixel(input pix_t px);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_pixel(px);
        @(negedge aclk);
    endtask

    function automatic pix_t random_pixel();
        pix_t px;
        int k;
        for (k = 0; k < 3; k++) begin
            case ($urandom_range(7))
                0: px[CH_W * k +: CH_W] = '0;
                1: px[CH_W * k +: CH_W] = '1;
                default: px[CH_W * k +: CH_W] = CH_W'($urandom);
            endcase
        end
        return px;
    endfunction

    task automatic send_random(input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++) send_pixel(random_pixel());
    endtask

    // waits until the block is idle, then writes all registers
    task automatic apply_setting(input logic [KROW_W-1:0] k_top, k_mid, k_bot,
                                 input logic bias, input logic [FRAME_DIM_W-1:0] w, h);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        int i;
        idx = '{REG_KERN_TOP, REG_KERN_MID, REG_KERN_BOT, REG_ADD_BIAS, REG_FRAME_W, REG_FRAME_H};
        val = '{k_top, k_mid, k_bot, CFG_DATA_W'(bias), CFG_DATA_W'(w), CFG_DATA_W'(h)};
        s_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(negedge aclk);
        // words that release no result may still be in flight
        repeat (10) @(negedge aclk);
        for (i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wr_data <= val[i];
            sb.set_register(idx[i], val[i]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [KROW_W-1:0] random_kernel_row();
        logic [KROW_W-1:0] row;
        int k;
        if ($urandom_range(2) == 0) begin
            row = {4'($urandom_range(15)), 32'($urandom)};
        end else begin
            // weights within +-1.25 keep most sums away from the clamp
            for (k = 0; k < 3; k++)
                row[COEF_W * k +: COEF_W] = COEF_W'($urandom_range(40)) - COEF_W'(20);
        end
        return row;
    endfunction

    task automatic random_frame(input logic [FRAME_DIM_W-1:0] w, h, input int hold);
        logic [KROW_W-1:0] rows [3];
        int k;
        for (k = 0; k < 3; k++) rows[k] = random_kernel_row();
        apply_setting(rows[0], rows[1], rows[2], 1'($urandom_range(1)), w, h);
        sink_hold_cycles = hold;
        send_random(sb.frame_pixels());
    endtask

    initial begin
        int phase;
        int k;
        int unsigned sent;
        pix_t px;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every weight at its positive extreme with bias: sums saturate high
        apply_setting({3{COEF_POS_MAX}}, {3{COEF_POS_MAX}}, {3{COEF_POS_MAX}}, 1'b1,
                      12'd3, 12'd3);
        for (k = 0; k < 9; k++) begin
            px[0 +: CH_W] = k[0] ? 8'd0 : 8'd255;
            px[CH_W +: CH_W] = k[0] ? 8'd255 : 8'd0;
            px[2 * CH_W +: CH_W] = (k == 4) ? 8'd0 : 8'd255;
            send_pixel(px);
        end

        // negative extreme, no bias, frame sizes below the minimum
        apply_setting({3{COEF_NEG_MAX}}, {3{COEF_NEG_MAX}}, {3{COEF_NEG_MAX}}, 1'b0,
                      12'd0, 12'd1);
        for (k = 0; k < 9; k++) begin
            px[0 +: CH_W] = 8'd255;
            px[CH_W +: CH_W] = k[1] ? 8'd255 : 8'd0;
            px[2 * CH_W +: CH_W] = 8'd0;
            send_pixel(px);
        end

        // center tap only, then both sizes shrink after six words of the 4x5 frame
        apply_setting('0, {12'd0, COEF_UNITY, 12'd0}, '0, 1'b1, 12'd4, 12'd5);
        send_random(6);
        apply_setting('0, {12'd0, COEF_UNITY, 12'd0}, '0, 1'b1, 12'd3, 12'd3);
        send_random(4);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            sent = 0;
            while (sent < 35) begin
                if (phase == 2 && sent == 0) begin
                    // long hold-off so the block backs up into its input
                    random_frame(12'd8, 12'd6, 300);
                end else begin
                    random_frame(FRAME_DIM_W'($urandom_range(9)),
                                 FRAME_DIM_W'($urandom_range(6)), 0);
                end
                sent += sb.frame_pixels();
            end
            if (phase == 0) begin
                // height written above the maximum: three rows, then the frame is cut short
                apply_setting(random_kernel_row(), random_kernel_row(), random_kernel_row(),
                              1'b1, 12'd3, 12'd4095);
                send_random(9);
                apply_setting(random_kernel_row(), random_kernel_row(), random_kernel_row(),
                              1'b0, 12'd3, 12'd3);
                send_random(3);
            end
        end

        s_tvalid <= 1'b0;
        for (k = 0; k < 4000 && sb.expected_pixels.size() != 0; k++) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/rgbc_pkg.sv
rtl/core/rgbc_line_ram.sv
rtl/core/rgbc_tap_cell.sv
rtl/core/rgbc_out_buf.sv
rtl/core/rgb_3x3_convolution_clamp.sv
dv/rgb_3x3_convolution_clamp_test.sv
